// File: hdl/grid_path_steering_controller_assert.svh
// Assertion macros for the checker file of the steering controller.
// Each macro takes a label, the clock, the active-low reset, a condition
// and the property that must follow from it.
`ifndef GRID_PATH_STEERING_CONTROLLER_ASSERT_SVH
`define GRID_PATH_STEERING_CONTROLLER_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define GPSC_ASSERT_NOW(label, clk_s, rst_s, pre, post) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) \
        else $error("steering controller check failed");

// The consequence must hold in the cycle after the condition.
`define GPSC_ASSERT_NEXT(label, clk_s, rst_s, pre, post) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
        else $error("steering controller check failed");

`endif

// File: hdl/gpsc_pkg.sv
package gpsc_pkg;

    localparam int NODE_W         = 16;
    localparam int COORD_W        = 16;
    localparam int SPEED_W        = 21;
    localparam int OP_W           = 2;
    localparam int TURN_W         = 3;
    localparam int PATH_DEPTH_DEF = 256;
    localparam int SPEED_SCALE    = 10;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_HOLD   = 2'd1,
        OP_POS    = 2'd2
    } op_t;

    typedef enum logic [TURN_W-1:0] {
        TURN_LEFT  = 3'd0,
        TURN_RIGHT = 3'd1,
        TURN_FWD   = 3'd2,
        TURN_UTURN = 3'd3,
        TURN_STOP  = 3'd4
    } turn_t;

    typedef enum logic [1:0] {
        HD_YP = 2'd0,
        HD_YN = 2'd1,
        HD_XP = 2'd2,
        HD_XN = 2'd3
    } head_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_WRAP
    } ctrl_state_t;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_SQUARE,
        DS_ROOT,
        DS_SCALE
    } dist_state_t;

    // Turn taken when the heading changes, indexed by new and then old heading.
    localparam turn_t TURN_TBL [4][4] = '{
        '{TURN_FWD,   TURN_UTURN, TURN_LEFT,  TURN_RIGHT},
        '{TURN_UTURN, TURN_FWD,   TURN_RIGHT, TURN_LEFT },
        '{TURN_RIGHT, TURN_LEFT,  TURN_FWD,   TURN_UTURN},
        '{TURN_LEFT,  TURN_RIGHT, TURN_UTURN, TURN_FWD  }
    };

    // Final turn when the path runs out, indexed by heading.
    localparam turn_t END_TURN [4] = '{TURN_STOP, TURN_UTURN, TURN_LEFT, TURN_RIGHT};

    typedef struct packed {
        logic              push;
        logic              clear;
        logic [NODE_W-1:0] node;
        logic              pop;
        logic              fetch;
    } q_ctrl_t;

    typedef struct packed {
        logic              empty;
        logic              single;
        logic [NODE_W-1:0] head_node;
        logic [NODE_W-1:0] next_node;
    } q_stat_t;

endpackage

// File: hdl/gpsc_if.sv
interface gpsc_cmd_if;
    import gpsc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic [NODE_W-1:0]         node_id;
    logic                      first_node;
    logic signed [COORD_W-1:0] self_x;
    logic signed [COORD_W-1:0] self_y;
    logic signed [COORD_W-1:0] goal_x;
    logic signed [COORD_W-1:0] goal_y;

    modport source (
        output valid, op, node_id, first_node, self_x, self_y, goal_x, goal_y,
        input  ready
    );
    modport sink (
        input  valid, op, node_id, first_node, self_x, self_y, goal_x, goal_y,
        output ready
    );
endinterface

interface gpsc_res_if;
    import gpsc_pkg::*;

    logic               valid;
    logic               ready;
    logic [TURN_W-1:0]  turn_code;
    logic [SPEED_W-1:0] speed;
    logic               busy_res;
    logic               mission_done;

    modport source (
        output valid, turn_code, speed, busy_res, mission_done,
        input  ready
    );
    modport sink (
        input  valid, turn_code, speed, busy_res, mission_done,
        output ready
    );
endinterface

interface gpsc_cfg_if;
    import gpsc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

// File: hdl/gpsc_path_queue.sv
module gpsc_path_queue #(
    parameter int PATH_DEPTH = gpsc_pkg::PATH_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  gpsc_pkg::q_ctrl_t ctrl,
    output gpsc_pkg::q_stat_t stat
);
    import gpsc_pkg::*;

    localparam int AW = $clog2(PATH_DEPTH);
    localparam int CW = $clog2(PATH_DEPTH + 1);

    logic [NODE_W-1:0] mem [PATH_DEPTH];

    logic [AW-1:0]     head_reg;
    logic [CW-1:0]     count_reg;
    logic              fetch_d1_reg;
    logic              fetch_d2_reg;
    logic [NODE_W-1:0] rd_data_reg;
    logic [NODE_W-1:0] head_node_reg;
    logic [NODE_W-1:0] next_node_reg;

    logic [AW:0]   tail_sum;
    logic [AW-1:0] tail_addr;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          full;
    logic          wr_en;

    // The tail is at most one lap ahead of the head, so one subtract wraps it.
    assign tail_sum  = (AW+1)'(head_reg) + (AW+1)'(count_reg);
    assign tail_addr = (tail_sum >= (AW+1)'(PATH_DEPTH))
                     ? AW'(tail_sum - (AW+1)'(PATH_DEPTH)) : AW'(tail_sum);
    assign head_inc  = (head_reg == AW'(PATH_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign full      = (count_reg == CW'(PATH_DEPTH));
    assign wr_en     = ctrl.push && (ctrl.clear || !full);
    assign wr_addr   = ctrl.clear ? '0 : tail_addr;

    // The head entry is read in the cycle of the fetch, the one behind it next.
    assign rd_addr = fetch_d1_reg ? head_inc : head_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= ctrl.node;
        end
        rd_data_reg <= mem[rd_addr];
        if (fetch_d1_reg)
        begin
            head_node_reg <= rd_data_reg;
        end
        if (fetch_d2_reg)
        begin
            next_node_reg <= rd_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            count_reg    <= '0;
            fetch_d1_reg <= 1'b0;
            fetch_d2_reg <= 1'b0;
        end
        else
        begin
            fetch_d1_reg <= ctrl.fetch;
            fetch_d2_reg <= fetch_d1_reg;
            if (ctrl.push)
            begin
                if (ctrl.clear)
                begin
                    head_reg  <= '0;
                    count_reg <= CW'(1);
                end
                else if (!full)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            else if (ctrl.pop)
            begin
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign stat.empty     = (count_reg == '0);
    assign stat.single    = (count_reg == CW'(1));
    assign stat.head_node = head_node_reg;
    assign stat.next_node = next_node_reg;

endmodule

// File: hdl/gpsc_dist_unit.sv
module gpsc_dist_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [gpsc_pkg::COORD_W-1:0] self_x,
    input  logic signed [gpsc_pkg::COORD_W-1:0] self_y,
    input  logic signed [gpsc_pkg::COORD_W-1:0] goal_x,
    input  logic signed [gpsc_pkg::COORD_W-1:0] goal_y,
    input  logic signed [gpsc_pkg::COORD_W-1:0] stop_distance,
    output logic                               done,
    output logic [gpsc_pkg::SPEED_W-1:0]       speed
);
    import gpsc_pkg::*;

    localparam int MAG_W  = COORD_W;
    localparam int PROD_W = 2 * MAG_W;
    localparam int SQ_W   = PROD_W + 2;
    localparam int ROOT_W = SQ_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int DIFF_W = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W);

    dist_state_t state_reg, state_next;

    logic [CNT_W-1:0]   cnt_reg;
    logic [MAG_W-1:0]   mx_reg;
    logic [MAG_W-1:0]   my_reg;
    logic [PROD_W-1:0]  ax_reg;
    logic [PROD_W-1:0]  ay_reg;
    logic [SQ_W-1:0]    acc_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic               done_reg;

    logic [MAG_W:0]     dx;
    logic [MAG_W:0]     dy;
    logic [MAG_W:0]     mag_x;
    logic [MAG_W:0]     mag_y;
    logic [SQ_W-1:0]    acc_sum;
    logic [REM_W-1:0]   rem_shift;
    logic [REM_W-1:0]   trial;
    logic               take;
    logic signed [DIFF_W-1:0] diff;
    logic               cnt_last;
    logic               in_square;
    logic               in_root;
    logic               in_scale;

    assign dx    = {self_x[COORD_W-1], self_x} - {goal_x[COORD_W-1], goal_x};
    assign dy    = {self_y[COORD_W-1], self_y} - {goal_y[COORD_W-1], goal_y};
    assign mag_x = dx[MAG_W] ? ((MAG_W+1)'(0) - dx) : dx;
    assign mag_y = dy[MAG_W] ? ((MAG_W+1)'(0) - dy) : dy;

    // One multiplier bit of each square is added per cycle.
    assign acc_sum = acc_reg
                   + (mx_reg[0] ? {2'b00, ax_reg} : '0)
                   + (my_reg[0] ? {2'b00, ay_reg} : '0);

    // Restoring square root: two radicand bits in, one root bit out per cycle.
    assign rem_shift = {rem_reg[REM_W-3:0], acc_reg[SQ_W-1:SQ_W-2]};
    assign trial     = {root_reg, 2'b01};
    assign take      = (rem_shift >= trial);

    assign diff = $signed({2'b00, root_reg})
                - $signed({{(DIFF_W-COORD_W){stop_distance[COORD_W-1]}}, stop_distance});

    assign cnt_last = (cnt_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DS_IDLE:
            begin
                if (start)
                begin
                    state_next = DS_SQUARE;
                end
            end
            DS_SQUARE:
            begin
                if (cnt_last)
                begin
                    state_next = DS_ROOT;
                end
            end
            DS_ROOT:
            begin
                if (cnt_last)
                begin
                    state_next = DS_SCALE;
                end
            end
            DS_SCALE:
            begin
                state_next = DS_IDLE;
            end
            default:
            begin
                state_next = DS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_square = 1'b0;
        in_root   = 1'b0;
        in_scale  = 1'b0;
        unique case (state_reg)
            DS_SQUARE: in_square = 1'b1;
            DS_ROOT:   in_root   = 1'b1;
            DS_SCALE:  in_scale  = 1'b1;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DS_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= in_scale;
            if (start && (state_reg == DS_IDLE))
            begin
                cnt_reg <= CNT_W'(MAG_W - 1);
            end
            else if (in_square && cnt_last)
            begin
                cnt_reg <= CNT_W'(ROOT_W - 1);
            end
            else if (!cnt_last)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && (state_reg == DS_IDLE))
        begin
            mx_reg   <= mag_x[MAG_W-1:0];
            my_reg   <= mag_y[MAG_W-1:0];
            ax_reg   <= PROD_W'(mag_x[MAG_W-1:0]);
            ay_reg   <= PROD_W'(mag_y[MAG_W-1:0]);
            acc_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (in_square)
        begin
            acc_reg <= acc_sum;
            mx_reg  <= mx_reg >> 1;
            my_reg  <= my_reg >> 1;
            ax_reg  <= {ax_reg[PROD_W-2:0], 1'b0};
            ay_reg  <= {ay_reg[PROD_W-2:0], 1'b0};
        end
        else if (in_root)
        begin
            acc_reg  <= {acc_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= take ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
        if (in_scale)
        begin
            speed_reg <= diff[DIFF_W-1] ? '0
                       : SPEED_W'(diff[DIFF_W-2:0]) * SPEED_W'(SPEED_SCALE);
        end
    end

    assign done  = done_reg;
    assign speed = speed_reg;

endmodule

// File: hdl/grid_path_steering_controller.sv
// Steering controller for a vehicle that drives along a path of numbered grid
// nodes. Path items (op append) load a ring queue of node ids; an item with
// first_node set empties the queue before it is stored. A hold item toggles
// the hold flag. A position item reports the node just reached and the x,y of
// the vehicle and its target, and returns exactly one result item with the
// turn command, the speed, the busy flag and a mission-done pulse; the other
// item kinds return nothing. The speed is (floor(sqrt(dx*dx + dy*dy)) -
// stop_distance) * 10, or zero when that is negative. After an append, hold
// or unused op code the block is ready again in the next cycle. For a
// position item the distance unit squares both deltas one multiplier bit per
// cycle, extracts the root one bit per cycle and scales it; its done strobe
// moves the controller to the wrap state, which registers the result once
// the output register is free. While a position item is in flight no other
// item is accepted; a finished result may wait at the output while the next
// item is taken. The queue reads its head and the node behind it from a
// memory with separate read and write ports during the distance computation.
// stop_distance is written through the configuration channel, which is always
// ready and must only be used while the block is idle.
module grid_path_steering_controller #(
    parameter int PATH_DEPTH = gpsc_pkg::PATH_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    gpsc_cmd_if.sink    cmd,
    gpsc_res_if.source  res,
    gpsc_cfg_if.sink    cfg
);
    import gpsc_pkg::*;

    ctrl_state_t state_reg, state_next;

    logic signed [COORD_W-1:0] stop_distance_reg;
    logic [NODE_W-1:0]         node_reg;
    head_t                     heading_reg;
    turn_t                     last_turn_reg;
    logic                      hold_reg;
    logic                      ended_reg;
    logic                      busy_reg;

    logic                      res_valid_reg;
    logic [TURN_W-1:0]         res_turn_reg;
    logic [SPEED_W-1:0]        res_speed_reg;
    logic                      res_busy_reg;
    logic                      res_done_reg;

    logic                      cmd_ready;
    logic                      accept;
    logic                      dist_start;
    logic                      dist_done;
    logic [SPEED_W-1:0]        dist_speed;
    logic                      slot_free;
    logic                      wrap_fire;

    q_ctrl_t                   q_ctrl;
    q_stat_t                   q_stat;

    // Outcome of the position update that is being closed out.
    turn_t                     turn_next;
    head_t                     heading_next;
    logic                      busy_next;
    logic                      ended_next;
    logic                      done_out;
    logic                      zero_speed;
    logic                      pop;
    logic                      head_hit;
    logic signed [NODE_W:0]    delta;

    gpsc_path_queue #(
        .PATH_DEPTH (PATH_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (q_ctrl),
        .stat  (q_stat)
    );

    gpsc_dist_unit u_dist (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (dist_start),
        .self_x        (cmd.self_x),
        .self_y        (cmd.self_y),
        .goal_x        (cmd.goal_x),
        .goal_y        (cmd.goal_y),
        .stop_distance (stop_distance_reg),
        .done          (dist_done),
        .speed         (dist_speed)
    );

    // The output register may still hold an earlier result; it is overwritten
    // only once that result has been taken.
    assign slot_free = !res_valid_reg || res.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid && (cmd.op == OP_POS))
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (dist_done)
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_ready = 1'b0;
        wrap_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE: cmd_ready = 1'b1;
            ST_WRAP: wrap_fire = slot_free;
            default: ;
        endcase
    end

    assign accept     = cmd.valid && cmd_ready;
    assign dist_start = accept && (cmd.op == OP_POS);

    assign q_ctrl.push  = accept && (cmd.op == OP_APPEND);
    assign q_ctrl.clear = cmd.first_node;
    assign q_ctrl.node  = cmd.node_id;
    assign q_ctrl.fetch = dist_start;
    assign q_ctrl.pop   = wrap_fire && pop;

    assign head_hit = (node_reg == q_stat.head_node);
    assign delta    = $signed({1'b0, q_stat.next_node}) - $signed({1'b0, q_stat.head_node});

    // Turn decision. A held vehicle stops without touching any state. With an
    // empty queue the first update after the path ends closes the mission with
    // a turn back to the Y+ heading. Reaching the head pops it; when another
    // node follows, the node-number delta picks the new heading, and a zero
    // delta keeps both heading and last turn.
    always_comb
    begin
        turn_next    = last_turn_reg;
        heading_next = heading_reg;
        busy_next    = busy_reg;
        ended_next   = ended_reg;
        done_out     = 1'b0;
        zero_speed   = 1'b0;
        pop          = 1'b0;
        if (hold_reg)
        begin
            turn_next  = TURN_STOP;
            zero_speed = 1'b1;
        end
        else if (q_stat.empty)
        begin
            if (!ended_reg)
            begin
                turn_next    = END_TURN[heading_reg];
                heading_next = HD_YP;
                busy_next    = 1'b0;
                ended_next   = 1'b1;
                done_out     = 1'b1;
            end
            else
            begin
                turn_next  = TURN_STOP;
                zero_speed = 1'b1;
            end
        end
        else if (q_stat.single)
        begin
            if (head_hit)
            begin
                turn_next = TURN_STOP;
                pop       = 1'b1;
            end
            else
            begin
                turn_next = TURN_FWD;
            end
        end
        else if (head_hit)
        begin
            pop = 1'b1;
            if (delta > 17'sd1)
            begin
                heading_next = HD_YP;
                turn_next    = TURN_TBL[HD_YP][heading_reg];
            end
            else if (delta < -17'sd1)
            begin
                heading_next = HD_YN;
                turn_next    = TURN_TBL[HD_YN][heading_reg];
            end
            else if (delta == 17'sd1)
            begin
                heading_next = HD_XP;
                turn_next    = TURN_TBL[HD_XP][heading_reg];
            end
            else if (delta == -17'sd1)
            begin
                heading_next = HD_XN;
                turn_next    = TURN_TBL[HD_XN][heading_reg];
            end
        end
        else if (!ended_reg)
        begin
            turn_next = TURN_FWD;
        end
        else
        begin
            turn_next  = TURN_STOP;
            zero_speed = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            stop_distance_reg <= '0;
            heading_reg       <= HD_YP;
            last_turn_reg     <= TURN_STOP;
            hold_reg          <= 1'b0;
            ended_reg         <= 1'b1;
            busy_reg          <= 1'b0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                stop_distance_reg <= cfg.data;
            end
            if (accept)
            begin
                unique case (cmd.op)
                    OP_APPEND:
                    begin
                        busy_reg  <= 1'b1;
                        ended_reg <= 1'b0;
                    end
                    OP_HOLD:
                    begin
                        hold_reg <= !hold_reg;
                    end
                    default: ;
                endcase
            end
            if (wrap_fire)
            begin
                heading_reg   <= heading_next;
                // The stop reported for a held update is not remembered.
                if (!hold_reg)
                begin
                    last_turn_reg <= turn_next;
                end
                busy_reg      <= busy_next;
                ended_reg     <= ended_next;
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dist_start)
        begin
            node_reg <= cmd.node_id;
        end
        if (wrap_fire)
        begin
            res_turn_reg  <= turn_next;
            res_speed_reg <= zero_speed ? '0 : dist_speed;
            res_busy_reg  <= busy_next;
            res_done_reg  <= done_out;
        end
    end

    assign cmd.ready        = cmd_ready;
    assign cfg.ready        = 1'b1;
    assign res.valid        = res_valid_reg;
    assign res.turn_code    = res_turn_reg;
    assign res.speed        = res_speed_reg;
    assign res.busy_res     = res_busy_reg;
    assign res.mission_done = res_done_reg;

endmodule

// File: hdl/gpsc_checker.sv
`include "grid_path_steering_controller_assert.svh"

module gpsc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic [gpsc_pkg::OP_W-1:0]     cmd_op,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [gpsc_pkg::TURN_W-1:0]   res_turn_code,
    input logic [gpsc_pkg::SPEED_W-1:0]  res_speed,
    input logic                          res_busy_res,
    input logic                          res_mission_done
);
    import gpsc_pkg::*;

    // A result that is not taken stays on the port unchanged.
    `GPSC_ASSERT_NEXT(a_res_stall, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_turn_code) && $stable(res_speed) && $stable(res_busy_res) && $stable(res_mission_done))

    // The update that ends the mission reports the vehicle as no longer busy.
    `GPSC_ASSERT_NOW(a_done_not_busy, clk, rst_n, res_valid && res_mission_done, !res_busy_res)

    // After a position item is taken, the block is not ready in the next cycle.
    `GPSC_ASSERT_NEXT(a_pos_blocks, clk, rst_n, cmd_valid && cmd_ready && cmd_op == OP_POS, !cmd_ready)

    // Path, hold and unused items finish in the cycle they are taken.
    `GPSC_ASSERT_NEXT(a_fast_ops, clk, rst_n, cmd_valid && cmd_ready && cmd_op != OP_POS, cmd_ready)

endmodule

bind grid_path_steering_controller gpsc_checker u_gpsc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd.valid),
    .cmd_ready        (cmd.ready),
    .cmd_op           (cmd.op),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .res_turn_code    (res.turn_code),
    .res_speed        (res.speed),
    .res_busy_res     (res.busy_res),
    .res_mission_done (res.mission_done)
);
